@@ src/sjq_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package sjq_pkg;

   // Storage geometry of the queue.
   localparam int DEPTH     = 16;
   localparam int TIME_BITS = 16;
   localparam int TAG_BITS  = 8;
   localparam int IDX_BITS  = $clog2(DEPTH);
   localparam int CNT_BITS  = $clog2(DEPTH + 1);
   localparam int OP_BITS   = 2;

   // Operation codes.
   localparam logic [OP_BITS-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_BITS-1:0] OP_DELETE = 2'd1;
   localparam logic [OP_BITS-1:0] OP_CLEAR  = 2'd2;

   // One stored job.
   typedef struct packed {
      logic [TIME_BITS-1:0] birth;
      logic [TIME_BITS-1:0] remaining;
      logic [TAG_BITS-1:0]  tag;
   } entry_type;

   // Per-cell control from the queue controller.
   typedef struct packed {
      logic valid;      // Cell holds a live job.
      logic at_end;     // Cell is the first free slot.
      logic del_shift;  // Cell is at or past the delete position.
      logic ins;        // An insert takes effect this cycle.
      logic del;        // A delete takes effect this cycle.
   } cell_ctrl_type;

endpackage

`default_nettype wire

@@ src/sjq_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none

module sjq_cell
   import sjq_pkg::*;
(
   input  wire logic          clock,
   input  wire cell_ctrl_type ctrl,
   input  wire logic          sort_key,
   input  wire entry_type     new_entry,
   input  wire entry_type     left_entry,
   input  wire entry_type     right_entry,
   input  wire logic          any_left,
   output logic               any_out,
   output entry_type          entry,
   output entry_type          entry_next
);

   entry_type            entry_ff;
   entry_type            entry_in;
   logic [TIME_BITS-1:0] own_key;
   logic [TIME_BITS-1:0] new_key;
   logic                 greater;

   // Compare the stored key with the key of the incoming job.
   assign own_key = sort_key ? entry_ff.remaining : entry_ff.birth;
   assign new_key = sort_key ? new_entry.remaining : new_entry.birth;
   assign greater = ctrl.valid && (own_key > new_key);
   assign any_out = any_left | greater;

   // An insert shifts right past the first greater key; a delete shifts left.
   always_comb begin
      entry_in = entry_ff;
      if (ctrl.ins) begin
         if (any_left) begin
            entry_in = left_entry;
         end else if (greater || ctrl.at_end) begin
            entry_in = new_entry;
         end
      end else if (ctrl.del && ctrl.del_shift) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry      = entry_ff;
   assign entry_next = entry_in;

endmodule

`default_nettype wire

@@ src/sorted_job_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Sorted job queue: up to DEPTH jobs held in ascending key order in a row of cells.
// Request channel (req_*): op selects insert, delete at req_position, or clear.
// Response channel (rsp_*): one transaction per request with ok, the new count and
// the head job (zeros when the list is empty).
// Configuration channel (csr_*): csr_sort_key picks the key, 0 birth time and
// 1 remaining time; csr_ready is always high. Change it only while the list is empty
// and no request is in flight.
// The response is registered: it appears in the cycle after its request is accepted.
// One request per cycle is sustained while the receiver does not stall, since
// every cell compares and shifts in parallel and the insert position travels along
// the row in the same cycle. When the receiver stalls while rsp_valid is high,
// the response register holds its transaction and req_stall rises.
// Reset empties the list, sets the key to remaining time and drops rsp_valid.
module sorted_job_queue
   import sjq_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic                 csr_sort_key,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic [OP_BITS-1:0]   req_op,
   input  wire logic [TIME_BITS-1:0] req_birth_time,
   input  wire logic [TIME_BITS-1:0] req_remaining_time,
   input  wire logic [TAG_BITS-1:0]  req_job_tag,
   input  wire logic [IDX_BITS-1:0]  req_position,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic                      rsp_ok,
   output logic [CNT_BITS-1:0]       rsp_count,
   output logic [TIME_BITS-1:0]      rsp_head_birth,
   output logic [TIME_BITS-1:0]      rsp_head_remaining,
   output logic [TAG_BITS-1:0]       rsp_head_tag
);

   logic                sort_key_ff;
   logic [CNT_BITS-1:0] count_ff;
   logic [CNT_BITS-1:0] count_in;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic                ok_ff;
   logic                ok_in;
   logic [CNT_BITS-1:0] rsp_count_ff;
   entry_type           head_ff;
   entry_type           head_in;
   logic                req_accept;
   logic                ins_ok;
   logic                del_ok;
   entry_type           new_entry;
   cell_ctrl_type       ctrl [DEPTH];
   entry_type           entries [DEPTH];
   entry_type           entries_next [DEPTH];
   logic                any_chain [DEPTH+1];

   // Configuration register.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         sort_key_ff <= 1'b1;
      end else if (csr_valid && csr_ready) begin
         sort_key_ff <= csr_sort_key;
      end
   end

   // Request handshake and operation legality.
   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;
   assign ins_ok     = (req_op == OP_INSERT) && (count_ff != CNT_BITS'(DEPTH));
   assign del_ok     = (req_op == OP_DELETE) && (CNT_BITS'(req_position) < count_ff);

   assign new_entry.birth     = req_birth_time;
   assign new_entry.remaining = req_remaining_time;
   assign new_entry.tag       = req_job_tag;

   // Per-cell control derived from the fill count.
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         ctrl[i].valid     = CNT_BITS'(i) < count_ff;
         ctrl[i].at_end    = CNT_BITS'(i) == count_ff;
         ctrl[i].del_shift = CNT_BITS'(i) >= CNT_BITS'(req_position);
         ctrl[i].ins       = req_accept && ins_ok;
         ctrl[i].del       = req_accept && del_ok;
      end
   end

   // Row of cells; the insert position travels along any_chain.
   assign any_chain[0] = 1'b0;

   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      entry_type left_entry;
      entry_type right_entry;

      if (g == 0) begin : g_first
         assign left_entry = new_entry;
      end else begin : g_mid
         assign left_entry = entries[g-1];
      end

      if (g == DEPTH - 1) begin : g_last
         assign right_entry = entries[g];
      end else begin : g_inner
         assign right_entry = entries[g+1];
      end

      sjq_cell u_cell (
         .clock       (clock),
         .ctrl        (ctrl[g]),
         .sort_key    (sort_key_ff),
         .new_entry   (new_entry),
         .left_entry  (left_entry),
         .right_entry (right_entry),
         .any_left    (any_chain[g]),
         .any_out     (any_chain[g+1]),
         .entry       (entries[g]),
         .entry_next  (entries_next[g])
      );
   end

   // Fill count update.
   always_comb begin
      count_in = count_ff;
      ok_in    = 1'b0;
      case (req_op)
         OP_INSERT: begin
            if (ins_ok) begin
               count_in = count_ff + CNT_BITS'(1);
               ok_in    = 1'b1;
            end
         end
         OP_DELETE: begin
            if (del_ok) begin
               count_in = count_ff - CNT_BITS'(1);
               ok_in    = 1'b1;
            end
         end
         OP_CLEAR: begin
            count_in = '0;
            ok_in    = 1'b1;
         end
         default: begin
            count_in = count_ff;
            ok_in    = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (req_accept) begin
         count_ff <= count_in;
      end
   end

   // Response register holds the transaction until the receiver takes it.
   assign head_in      = (count_in != '0) ? entries_next[0] : '0;
   assign rsp_valid_in = req_accept || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         ok_ff        <= ok_in;
         rsp_count_ff <= count_in;
         head_ff      <= head_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_ok             = ok_ff;
   assign rsp_count          = rsp_count_ff;
   assign rsp_head_birth     = head_ff.birth;
   assign rsp_head_remaining = head_ff.remaining;
   assign rsp_head_tag       = head_ff.tag;

endmodule

`default_nettype wire

@@ test/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
   import sjq_pkg::*;

   // Operation code that the block does not define; it must be answered with ok=0.
   localparam logic [OP_BITS-1:0] OP_UNUSED = 2'd3;

   localparam int CYCLE_LIMIT = 200000;
   localparam int HOLD_CYCLES = 48;
   localparam int PHASES      = 6;

   // One response transaction as the block reports it.
   typedef struct packed {
      logic                 ok;
      logic [CNT_BITS-1:0]  count;
      logic [TIME_BITS-1:0] birth;
      logic [TIME_BITS-1:0] remaining;
      logic [TAG_BITS-1:0]  tag;
   } head_report_type;

   // Mirror of the sorted list; it predicts the head report of every accepted request.
   class queue_mirror;
      entry_type       slots [DEPTH];
      int unsigned     fill;
      logic            by_remaining;
      head_report_type expected_reports [$];
      int unsigned     failures;
      int unsigned     checked;
      int unsigned     inserts, deletes, clears, unused_ops, full_hits, peak_fill;

      function new();
         fill = 0;
         by_remaining = 1'b1;
         failures = 0;
         checked = 0;
         inserts = 0;
         deletes = 0;
         clears = 0;
         unused_ops = 0;
         full_hits = 0;
         peak_fill = 0;
      endfunction

      function void set_key(logic remaining_first);
         by_remaining = remaining_first;
      endfunction

      // Apply one accepted request and queue the report it must produce.
      function void apply_request(logic [OP_BITS-1:0] op, entry_type job,
                                  logic [IDX_BITS-1:0] pos);
         int unsigned          slot;
         logic                 ok;
         logic [TIME_BITS-1:0] new_key;
         logic [TIME_BITS-1:0] old_key;
         head_report_type      report;
         ok = 1'b0;
         case (op)
            OP_INSERT: begin
               inserts++;
               if (fill < DEPTH) begin
                  // The new job goes before the first entry with a strictly greater key.
                  new_key = by_remaining ? job.remaining : job.birth;
                  slot = fill;
                  for (int i = 0; i < fill; i++) begin
                     old_key = by_remaining ? slots[i].remaining : slots[i].birth;
                     if (old_key > new_key && slot == fill) begin
                        slot = i;
                     end
                  end
                  for (int i = fill; i > slot; i--) begin
                     slots[i] = slots[i-1];
                  end
                  slots[slot] = job;
                  fill++;
                  ok = 1'b1;
               end else begin
                  full_hits++;
               end
            end
            OP_DELETE: begin
               deletes++;
               if (pos < fill) begin
                  for (int i = pos; i + 1 < fill; i++) begin
                     slots[i] = slots[i+1];
                  end
                  fill--;
                  ok = 1'b1;
               end
            end
            OP_CLEAR: begin
               clears++;
               fill = 0;
               ok = 1'b1;
            end
            default: begin
               unused_ops++;
            end
         endcase
         if (fill > peak_fill) begin
            peak_fill = fill;
         end
         report.ok = ok;
         report.count = CNT_BITS'(fill);
         if (fill > 0) begin
            report.birth = slots[0].birth;
            report.remaining = slots[0].remaining;
            report.tag = slots[0].tag;
         end else begin
            report.birth = '0;
            report.remaining = '0;
            report.tag = '0;
         end
         expected_reports.push_back(report);
      endfunction

      // Compare one accepted response with the oldest expected report.
      function void check_report(head_report_type got);
         head_report_type want;
         if (expected_reports.size() == 0) begin
            failures++;
            if (failures <= 10) begin
               $display("Error at %0t: response with no request outstanding", $time);
            end
            return;
         end
         want = expected_reports.pop_front();
         checked++;
         if (got.ok !== want.ok || got.count !== want.count || got.birth !== want.birth ||
             got.remaining !== want.remaining || got.tag !== want.tag) begin
            failures++;
            if (failures <= 10) begin
               $display("Error at %0t: expected ok=%0d count=%0d head=(%0d,%0d,%0d)",
                        $time, want.ok, want.count, want.birth, want.remaining, want.tag);
               $display("              actual   ok=%0d count=%0d head=(%0d,%0d,%0d)",
                        got.ok, got.count, got.birth, got.remaining, got.tag);
            end
         end
      endfunction
   endclass

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic                 csr_sort_key = 1'b0;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [OP_BITS-1:0]   req_op = OP_INSERT;
   logic [TIME_BITS-1:0] req_birth_time = '0;
   logic [TIME_BITS-1:0] req_remaining_time = '0;
   logic [TAG_BITS-1:0]  req_job_tag = '0;
   logic [IDX_BITS-1:0]  req_position = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic                 rsp_ok;
   logic [CNT_BITS-1:0]  rsp_count;
   logic [TIME_BITS-1:0] rsp_head_birth;
   logic [TIME_BITS-1:0] rsp_head_remaining;
   logic [TAG_BITS-1:0]  rsp_head_tag;

   queue_mirror board;
   int          cycle_count = 0;
   int          stall_left = 0;
   logic        hold_trigger = 1'b0;
   logic        hold_done = 1'b0;
   logic        req_idle_on = 1'b0;
   logic        rsp_idle_on = 1'b0;

   sorted_job_queue dut (
      .clock              (clock),
      .reset              (reset),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_sort_key       (csr_sort_key),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_op             (req_op),
      .req_birth_time     (req_birth_time),
      .req_remaining_time (req_remaining_time),
      .req_job_tag        (req_job_tag),
      .req_position       (req_position),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_ok             (rsp_ok),
      .rsp_count          (rsp_count),
      .rsp_head_birth     (rsp_head_birth),
      .rsp_head_remaining (rsp_head_remaining),
      .rsp_head_tag       (rsp_head_tag)
   );

   // Clock with a 20 ns period.
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Cycle counter that ends a run that hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Run stopped after %0d cycles without finishing.", CYCLE_LIMIT);
         $display("testbench NOT OK");
         $finish;
      end
   end

   // Receiver: random stall bursts, plus one long hold-off counted here in cycles.
   always @(negedge clock) begin
      if (hold_trigger && !hold_done) begin
         stall_left = HOLD_CYCLES;
         hold_done = 1'b1;
      end
      if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left = stall_left - 1;
      end else if (rsp_idle_on && !reset && $urandom_range(0, 5) == 0) begin
         rsp_stall <= 1'b1;
         stall_left = $urandom_range(0, 3);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Every response transaction is checked at the edge that accepts it.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         board.check_report('{ok: rsp_ok, count: rsp_count, birth: rsp_head_birth,
                              remaining: rsp_head_remaining, tag: rsp_head_tag});
      end
   end

   // Offer one request transaction and wait until the block takes it.
   task automatic send_request(input logic [OP_BITS-1:0]   op,
                               input logic [TIME_BITS-1:0] birth,
                               input logic [TIME_BITS-1:0] remaining,
                               input logic [TAG_BITS-1:0]  tag,
                               input logic [IDX_BITS-1:0]  pos);
      entry_type job;
      job.birth = birth;
      job.remaining = remaining;
      job.tag = tag;
      if (req_idle_on && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_birth_time <= birth;
      req_remaining_time <= remaining;
      req_job_tag <= tag;
      req_position <= pos;
      do @(posedge clock); while (req_stall);
      board.apply_request(op, job, pos);
      @(negedge clock);
   endtask

   // Stop offering requests and wait until every response has come back.
   task automatic drain_responses();
      req_valid <= 1'b0;
      while (board.expected_reports.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
      @(negedge clock);
   endtask

   // Write the sort key register; only called while the block is idle.
   task automatic write_sort_key(input logic remaining_first);
      csr_valid <= 1'b1;
      csr_sort_key <= remaining_first;
      do @(posedge clock); while (!csr_ready);
      board.set_key(remaining_first);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Time values lean toward a few small values and the extremes, so equal keys are common.
   function automatic logic [TIME_BITS-1:0] pick_time();
      case ($urandom_range(0, 3))
         0: pick_time = TIME_BITS'($urandom_range(0, 7));
         1: pick_time = $urandom_range(0, 1) ? '1 : '0;
         default: pick_time = TIME_BITS'($urandom_range(0, (1 << TIME_BITS) - 1));
      endcase
   endfunction

   initial begin
      int                  insert_share [PHASES] = '{60, 75, 45, 50, 55, 55};
      logic                key_plan     [PHASES] = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
      logic                idle_plan    [PHASES] = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
      int                  roll;
      logic [OP_BITS-1:0]  op;
      logic [IDX_BITS-1:0] pos;
      board = new();

      // Synchronous reset, released on a falling clock edge.
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed requests under the reset key (remaining time).
      send_request(OP_DELETE, '0, '0, '0, '0);
      send_request(OP_CLEAR, '0, '0, '0, '0);
      send_request(OP_UNUSED, '1, '1, '1, '1);
      send_request(OP_INSERT, '0, '1, '1, '0);
      send_request(OP_INSERT, '1, '0, '0, '1);
      // Equal key: the later job must land behind the earlier one.
      send_request(OP_INSERT, 16'h1234, '0, 8'h01, '0);
      send_request(OP_DELETE, '0, '0, '0, 4'd15);
      send_request(OP_DELETE, '0, '0, '0, 4'd3);
      send_request(OP_DELETE, '0, '0, '0, 4'd1);
      // Fill the list to the top, then try one insert too many.
      for (int i = 2; i < DEPTH; i++) begin
         send_request(OP_INSERT, TIME_BITS'(i * 4099), TIME_BITS'((i * 7919) % 65536),
                      TAG_BITS'(i * 17), '0);
      end
      send_request(OP_INSERT, 16'h5555, 16'hAAAA, 8'h5A, '0);
      send_request(OP_DELETE, '0, '0, '0, 4'd15);
      send_request(OP_CLEAR, '0, '0, '0, '0);
      drain_responses();

      // Random phases; some key changes happen with jobs still stored.
      for (int phase = 0; phase < PHASES; phase++) begin
         if (phase == 2 || phase == 4) begin
            write_sort_key(key_plan[phase]);
         end else begin
            send_request(OP_CLEAR, '0, '0, '0, '0);
            drain_responses();
            write_sort_key(key_plan[phase]);
         end
         @(posedge clock);
         req_idle_on = idle_plan[phase];
         rsp_idle_on = idle_plan[phase];
         if (phase == 1) begin
            hold_trigger = 1'b1;
         end
         @(negedge clock);
         for (int n = 0; n < (phase == PHASES - 1 ? 100 : 90); n++) begin
            roll = $urandom_range(0, 99);
            pos = IDX_BITS'($urandom_range(0, DEPTH - 1));
            if (roll < insert_share[phase]) begin
               op = OP_INSERT;
            end else if (roll < 95) begin
               op = OP_DELETE;
               if (board.fill > 0 && $urandom_range(0, 3) != 0) begin
                  pos = IDX_BITS'($urandom_range(0, board.fill - 1));
               end
            end else if (roll < 98) begin
               op = OP_CLEAR;
            end else begin
               op = OP_UNUSED;
            end
            send_request(op, pick_time(), pick_time(), TAG_BITS'($urandom_range(0, 255)), pos);
         end
         drain_responses();
      end

      repeat (5) @(posedge clock);
      $display("Checked %0d responses: %0d inserts, %0d deletes, %0d clears, %0d unused ops.",
               board.checked, board.inserts, board.deletes, board.clears, board.unused_ops);
      $display("Peak fill %0d, %0d inserts refused as full, both sort keys, %0d-cycle hold-off.",
               board.peak_fill, board.full_hits, HOLD_CYCLES);
      if (board.failures == 0 && board.expected_reports.size() == 0) begin
         $display("testbench OK");
      end else begin
         $display("%0d mismatches, %0d responses missing.", board.failures,
                  board.expected_reports.size());
         $display("testbench NOT OK");
      end
      $finish;
   end

endmodule
